[rtl/core/cce_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cce_pkg
// Shared types, codes and character helpers of the control character escaper.
// ----------------------------------------------------------------------------
package cce_pkg;

  // Rendering kinds chosen by the front end for one raw byte.
  typedef logic [2:0] kind_t;
  localparam kind_t KIND_PLAIN     = 3'd0;  // the byte itself
  localparam kind_t KIND_DBL_BSL   = 3'd1;  // backslash backslash
  localparam kind_t KIND_CARET_ESC = 3'd2;  // backslash caret
  localparam kind_t KIND_LETTER    = 3'd3;  // backslash letter
  localparam kind_t KIND_CARET     = 3'd4;  // caret, byte plus 64
  localparam kind_t KIND_OCT3      = 3'd5;  // backslash three octal digits
  localparam kind_t KIND_OCTO      = 3'd6;  // backslash o three octal digits
  localparam kind_t KIND_HEX       = 3'd7;  // backslash x two hex digits

  // Configuration register indexes.
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_OCTAL_MODE     = 2'd0;
  localparam cfg_idx_t CFG_HEX_MODE       = 2'd1;
  localparam cfg_idx_t CFG_ESCAPE_NEWLINE = 2'd2;
  localparam cfg_idx_t CFG_ESCAPE_TAB     = 2'd3;

  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_O  = 8'h6F;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CARET_OFFSET = 8'd64;

  typedef logic [2:0] seq_idx_t;

  // One queued job: the chosen rendering and the byte it applies to.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } entry_t;

  // Configuration state handed from the register file to the classifier.
  typedef struct packed {
    logic octal_mode;
    logic hex_mode;
    logic escape_newline;
    logic escape_tab;
  } cfg_t;

  function automatic seq_idx_t seq_len(input kind_t kind);
    seq_idx_t len;
    case (kind)
      KIND_PLAIN: len = 3'd1;
      KIND_OCT3:  len = 3'd4;
      KIND_OCTO:  len = 3'd5;
      KIND_HEX:   len = 3'd4;
      default:    len = 3'd2;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] esc_letter(input logic [7:0] b);
    logic [7:0] c;
    case (b)
      8'd7:    c = 8'h61;  // a
      8'd8:    c = 8'h62;  // b
      8'd9:    c = 8'h74;  // t
      8'd10:   c = 8'h6E;  // n
      8'd11:   c = 8'h76;  // v
      8'd12:   c = 8'h66;  // f
      8'd13:   c = 8'h72;  // r
      default: c = 8'h3F;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] oct_digit(input logic [2:0] v);
    return CH_ZERO + {5'd0, v};
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] c;
    if (v < 4'd10) begin
      c = CH_ZERO + {4'd0, v};
    end else begin
      c = CH_LO_A + {4'd0, v} - 8'd10;
    end
    return c;
  endfunction

  // Character at position idx of the rendering of entry e.
  function automatic logic [7:0] seq_char(input entry_t e, input seq_idx_t idx);
    logic [7:0] c;
    logic [7:0] o2, o1, o0;
    o2 = oct_digit({1'b0, e.data[7:6]});
    o1 = oct_digit(e.data[5:3]);
    o0 = oct_digit(e.data[2:0]);
    c  = CH_BSL;
    case (e.kind)
      KIND_PLAIN:     c = e.data;
      KIND_DBL_BSL:   c = CH_BSL;
      KIND_CARET_ESC: c = (idx == 3'd0) ? CH_BSL : CH_CARET;
      KIND_LETTER:    c = (idx == 3'd0) ? CH_BSL : esc_letter(e.data);
      KIND_CARET:     c = (idx == 3'd0) ? CH_CARET : e.data + CARET_OFFSET;
      KIND_OCT3: begin
        case (idx)
          3'd1:    c = o2;
          3'd2:    c = o1;
          3'd3:    c = o0;
          default: c = CH_BSL;
        endcase
      end
      KIND_OCTO: begin
        case (idx)
          3'd1:    c = CH_LO_O;
          3'd2:    c = o2;
          3'd3:    c = o1;
          3'd4:    c = o0;
          default: c = CH_BSL;
        endcase
      end
      KIND_HEX: begin
        case (idx)
          3'd1:    c = CH_LO_X;
          3'd2:    c = hex_digit(e.data[7:4]);
          3'd3:    c = hex_digit(e.data[3:0]);
          default: c = CH_BSL;
        endcase
      end
      default: c = CH_BSL;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

[rtl/core/control_char_escaper.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// control_char_escaper
// Renders raw bytes as printable escaped character sequences.
// ----------------------------------------------------------------------------
// Usage: a raw byte arrives as one beat on in_valid/in_ready/in_byte. The
// block returns its printable form as 1 to 5 beats on out_valid/out_ready,
// each carrying out_char, with out_last_char high on the final character.
// Four mode bits are written through cfg_valid/cfg_index/cfg_data; cfg_ready
// is always high. Write them only while no byte is in flight.
// The first character of a byte is presented once the byte has passed the
// queue and has then been loaded into the output register. The output gives
// one character per cycle while out_ready is high and the queue holds a job;
// the single output register that serializes the characters sets this rate.
// A queue of QUEUE_DEPTH classified bytes sits between the front end and the
// serializer, so in_ready stays high until the queue fills while the
// receiver stalls; a stalled output holds its character.
// Reset clears the mode bits, empties the queue and drops out_valid.
// ----------------------------------------------------------------------------
module control_char_escaper import cce_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic       cfg_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_char,
  output logic            out_last_char
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic          push;
  entry_t        push_entry;
  logic          pop;
  entry_t        head;
  logic          q_not_empty;
  logic          q_not_full;
  logic [CW-1:0] q_count;

  assign cfg_ready = 1'b1;

  cce_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_byte    (in_byte),
    .q_not_full (q_not_full),
    .in_ready   (in_ready),
    .push       (push),
    .push_entry (push_entry)
  );

  cce_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .not_empty  (q_not_empty),
    .not_full   (q_not_full),
    .count      (q_count)
  );

  cce_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head),
    .head_valid    (q_not_empty),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_char      (out_char),
    .out_last_char (out_last_char)
  );

  // The queue never holds more entries than it has room for.
  assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= CW'(QUEUE_DEPTH))
    else $error("queue count exceeds depth");

  // Nothing is presented right after reset.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // A character can only appear when the queue held a job the cycle before.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(q_count) != '0)
    else $error("output produced from an empty queue");

  // An empty queue always has room for the next byte.
  assert property (@(posedge clk) disable iff (!rst_n)
    (q_count == '0) |-> in_ready)
    else $error("input stalled with an empty queue");

endmodule
`default_nettype wire

[rtl/core/cce_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cce_front
// Holds the mode registers and classifies each incoming byte into a kind.
// ----------------------------------------------------------------------------
module cce_front import cce_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_valid,
  input  wire cfg_idx_t   cfg_index,
  input  wire logic       cfg_data,
  input  wire logic       in_valid,
  input  wire logic [7:0] in_byte,
  input  wire logic       q_not_full,
  output logic            in_ready,
  output logic            push,
  output entry_t          push_entry
);

  cfg_t  cfg_r, cfg_nxt;
  kind_t numeric_kind;
  kind_t kind;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_OCTAL_MODE:     cfg_nxt.octal_mode     = cfg_data;
        CFG_HEX_MODE:       cfg_nxt.hex_mode       = cfg_data;
        CFG_ESCAPE_NEWLINE: cfg_nxt.escape_newline = cfg_data;
        CFG_ESCAPE_TAB:     cfg_nxt.escape_tab     = cfg_data;
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Numeric mode overrides: octal wins over hex.
  always_comb begin
    numeric_kind = cfg_r.octal_mode ? KIND_OCTO : KIND_HEX;
  end

  always_comb begin
    if (in_byte == CH_BSL) begin
      kind = KIND_DBL_BSL;
    end else if (in_byte == CH_CARET) begin
      kind = (cfg_r.octal_mode || cfg_r.hex_mode) ? numeric_kind : KIND_CARET_ESC;
    end else if (in_byte >= CH_SPACE && in_byte <= CH_TILDE) begin
      kind = KIND_PLAIN;
    end else if (in_byte == CH_NL && !cfg_r.escape_newline) begin
      kind = KIND_PLAIN;
    end else if (in_byte == CH_TAB && !cfg_r.escape_tab) begin
      kind = KIND_PLAIN;
    end else if (cfg_r.octal_mode || cfg_r.hex_mode) begin
      kind = numeric_kind;
    end else if (in_byte < CH_SPACE) begin
      kind = (in_byte >= 8'd7 && in_byte <= 8'd13) ? KIND_LETTER : KIND_CARET;
    end else begin
      kind = KIND_OCT3;
    end
  end

  assign in_ready        = q_not_full;
  assign push            = in_valid && q_not_full;
  assign push_entry.kind = kind;
  assign push_entry.data = in_byte;

endmodule
`default_nettype wire

[rtl/core/cce_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cce_queue
// Small FIFO of classified bytes between the front end and the serializer.
// ----------------------------------------------------------------------------
module cce_queue import cce_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     push,
  input  wire entry_t                   push_entry,
  input  wire logic                     pop,
  output entry_t                        head,
  output logic                          not_empty,
  output logic                          not_full,
  output logic [$clog2(DEPTH+1)-1:0]    count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  entry_t        mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign do_push = push && (cnt_r != FULL_CNT);
  assign do_pop  = pop && (cnt_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  assign head      = mem[rd_ptr_r];
  assign not_empty = (cnt_r != '0);
  assign not_full  = (cnt_r != FULL_CNT);
  assign count     = cnt_r;

endmodule
`default_nettype wire

[rtl/core/cce_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cce_back
// Expands the queue head into characters, one per cycle unless the output
// stalls, into the output register.
// ----------------------------------------------------------------------------
module cce_back import cce_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire entry_t     head,
  input  wire logic       head_valid,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_char,
  output logic            out_last_char
);

  seq_idx_t   idx_r, idx_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] char_r;
  logic       last_r;
  logic       load;
  logic       is_last;

  // The output register takes a new character whenever the queue has a job and
  // the register is empty or its current beat leaves this cycle.
  assign load    = head_valid && (!valid_r || out_ready);
  assign is_last = (idx_r == seq_len(head.kind) - 3'd1);
  assign pop     = load && is_last;

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    if (out_ready) begin
      valid_nxt = 1'b0;
    end
    if (load) begin
      valid_nxt = 1'b1;
      idx_nxt   = is_last ? '0 : idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      char_r <= seq_char(head, idx_r);
      last_r <= is_last;
    end
  end

  assign out_valid     = valid_r;
  assign out_char      = char_r;
  assign out_last_char = last_r;

endmodule
`default_nettype wire
